// ----- rtl/tpad_pkg.sv -----
`default_nettype none

package tpad_pkg;

  localparam int ANGLE_W   = 19;
  localparam int TICK_W    = 16;
  localparam int COUNT_W   = 8;
  localparam int PULSE_W   = 4;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 19;
  localparam int PROD_W    = 35;

  localparam logic [PULSE_W-1:0] PULSE_TICKS    = 4'd10;
  localparam logic [PROD_W-1:0]  FULL_TURN_MDEG = 35'd360000;
  localparam logic [TICK_W-1:0]  TICK_MAX       = 16'hFFFF;
  localparam logic [ANGLE_W-1:0] ANGLE_MAX      = 19'h7FFFF;
  localparam logic [COUNT_W-1:0] COUNT_MAX      = 8'hFF;

  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_MIN     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_MAX     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_ANGLE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAINS_PERIOD  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_CROSS  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CYCLE_CROSS   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_ADJUST_INTVL  = 3'd6;

  localparam logic [ANGLE_W-1:0] ALPHA_MIN_RESET     = 19'd10000;
  localparam logic [ANGLE_W-1:0] ALPHA_MAX_RESET     = 19'd160000;
  localparam logic [ANGLE_W-1:0] INITIAL_ANGLE_RESET = 19'd36000;
  localparam logic [TICK_W-1:0]  MAINS_PERIOD_RESET  = 16'd20000;
  localparam logic [COUNT_W-1:0] ENABLE_CROSS_RESET  = 8'd100;
  localparam logic [COUNT_W-1:0] CYCLE_CROSS_RESET   = 8'd200;
  localparam logic [TICK_W-1:0]  ADJUST_INTVL_RESET  = 16'd100;

  typedef struct packed {
    logic zc_level;
    logic zc_irq_level;
    logic button_up;
    logic button_down;
  } in_word_t;

  typedef struct packed {
    logic               gate;
    logic               firing_enabled;
    logic [ANGLE_W-1:0] angle_mdeg;
  } out_word_t;

endpackage

`default_nettype wire

// ----- rtl/triac_phase_angle_dimmer_top.sv -----
// Channel  Direction  Handshake           Word
// in       input      in_valid/in_stall   in_word_t: zc_level, zc_irq_level, buttons
// out      output     out_valid/out_stall out_word_t: gate, firing_enabled, angle_mdeg
// cfg      input      cfg_we              cfg_index, cfg_data
//
// One word per cycle is sustained while the output is not stalled; each word
// is held in the input register and processed on its move to the output register.
// The firing test is one 16 by 19 bit multiply and a 35 bit compare per word.
// Reset is synchronous; it restores the config, state and angle, not the word data.
// A stall on the output holds both stages; the input stalls only when both are full.

`default_nettype none

module triac_phase_angle_dimmer_top
  import tpad_pkg::*;
(
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        in_valid,
  output logic                       in_stall,
  input  wire in_word_t              in_word,
  output logic                       out_valid,
  input  wire                        out_stall,
  output out_word_t                  out_word,
  input  wire                        cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_W-1:0]      cfg_data
);

  logic [ANGLE_W-1:0] alpha_min_mdeg;
  logic [ANGLE_W-1:0] alpha_max_mdeg;
  logic [TICK_W-1:0]  mains_period_us;
  logic [COUNT_W-1:0] enable_crossings;
  logic [COUNT_W-1:0] cycle_crossings;
  logic [TICK_W-1:0]  adjust_interval;

  logic               stage_valid;
  in_word_t           stage_word;
  logic               advance;
  logic               load_stage;

  logic [TICK_W-1:0]  elapsed_ticks;
  logic [PROD_W-1:0]  elapsed_scaled;
  logic               fired_flag;
  logic               last_zc;
  logic               last_irq;
  logic [PULSE_W-1:0] pulse_left;
  logic [COUNT_W-1:0] crossing_count;
  logic [ANGLE_W-1:0] angle;
  logic [TICK_W-1:0]  adjust_timer;

  logic [TICK_W-1:0]  elapsed_ticks_next;
  logic [PROD_W-1:0]  elapsed_scaled_next;
  logic               fired_flag_next;
  logic               last_zc_next;
  logic [PULSE_W-1:0] pulse_left_next;
  logic [COUNT_W-1:0] crossing_count_next;
  logic [ANGLE_W-1:0] angle_next;
  logic [TICK_W-1:0]  adjust_timer_next;

  logic [COUNT_W-1:0] count_inc;
  logic               enabled;
  logic               restart;
  logic               fired_mid;
  logic [PROD_W-1:0]  scaled_mid;
  logic [PROD_W-1:0]  threshold;
  logic               fire;
  logic [PULSE_W-1:0] pulse_mid;
  logic               gate;
  logic               clear_timer;
  logic [TICK_W-1:0]  elapsed_mid;
  logic [PROD_W-1:0]  scaled_clr;
  logic [TICK_W-1:0]  adjust_inc;

  assign advance    = !out_valid || !out_stall;
  assign load_stage = advance || !stage_valid;
  assign in_stall   = !load_stage;

  // The initial angle only matters at reset, which also restores its default,
  // so a write to it has no lasting effect and is not stored.
  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_min_mdeg   <= ALPHA_MIN_RESET;
      alpha_max_mdeg   <= ALPHA_MAX_RESET;
      mains_period_us  <= MAINS_PERIOD_RESET;
      enable_crossings <= ENABLE_CROSS_RESET;
      cycle_crossings  <= CYCLE_CROSS_RESET;
      adjust_interval  <= ADJUST_INTVL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ALPHA_MIN:     alpha_min_mdeg   <= cfg_data[ANGLE_W-1:0];
        CFG_ALPHA_MAX:     alpha_max_mdeg   <= cfg_data[ANGLE_W-1:0];
        CFG_INITIAL_ANGLE: ;
        CFG_MAINS_PERIOD:  mains_period_us  <= cfg_data[TICK_W-1:0];
        CFG_ENABLE_CROSS:  enable_crossings <= cfg_data[COUNT_W-1:0];
        CFG_CYCLE_CROSS:   cycle_crossings  <= cfg_data[COUNT_W-1:0];
        CFG_ADJUST_INTVL:  adjust_interval  <= cfg_data[TICK_W-1:0];
        default:           ;
      endcase
    end
  end

  always_comb begin
    count_inc = crossing_count;
    if (stage_word.zc_irq_level && !last_irq && crossing_count != COUNT_MAX) begin
      count_inc = crossing_count + 8'd1;
    end
    enabled = (count_inc <= enable_crossings);
    crossing_count_next = count_inc;
    if (!enabled && count_inc > cycle_crossings) begin
      crossing_count_next = '0;
    end

    last_zc_next = last_zc;
    restart      = 1'b0;
    if (enabled) begin
      if (!stage_word.zc_level) begin
        last_zc_next = 1'b0;
      end else if (!last_zc) begin
        last_zc_next = 1'b1;
        restart      = 1'b1;
      end
    end
    fired_mid  = restart ? 1'b0 : fired_flag;
    scaled_mid = restart ? '0 : elapsed_scaled;

    threshold = PROD_W'(mains_period_us) * PROD_W'(angle);
    fire      = enabled && !fired_mid && (scaled_mid >= threshold);
    fired_flag_next = fire ? 1'b1 : fired_mid;

    pulse_mid       = fire ? PULSE_TICKS : pulse_left;
    gate            = (pulse_mid != '0);
    pulse_left_next = gate ? pulse_mid - 4'd1 : pulse_mid;

    clear_timer = restart || fire;
    elapsed_mid = clear_timer ? '0 : elapsed_ticks;
    scaled_clr  = clear_timer ? '0 : elapsed_scaled;
    if (elapsed_mid != TICK_MAX) begin
      elapsed_ticks_next  = elapsed_mid + 16'd1;
      elapsed_scaled_next = scaled_clr + FULL_TURN_MDEG;
    end else begin
      elapsed_ticks_next  = elapsed_mid;
      elapsed_scaled_next = scaled_clr;
    end

    adjust_inc        = adjust_timer + 16'd1;
    adjust_timer_next = '0;
    angle_next        = angle;
    if (stage_word.button_up != stage_word.button_down) begin
      adjust_timer_next = adjust_inc;
      if (adjust_inc >= adjust_interval) begin
        adjust_timer_next = '0;
        if (stage_word.button_up) begin
          if (angle <= alpha_max_mdeg && angle != ANGLE_MAX) begin
            angle_next = angle + 19'd1;
          end
        end else begin
          if (angle >= alpha_min_mdeg && angle != '0) begin
            angle_next = angle - 19'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid    <= 1'b0;
      out_valid      <= 1'b0;
      elapsed_ticks  <= '0;
      elapsed_scaled <= '0;
      fired_flag     <= 1'b0;
      last_zc        <= 1'b1;
      last_irq       <= 1'b0;
      pulse_left     <= '0;
      crossing_count <= '0;
      angle          <= INITIAL_ANGLE_RESET;
      adjust_timer   <= '0;
    end else begin
      if (load_stage) begin
        stage_valid <= in_valid;
      end
      if (advance) begin
        out_valid <= stage_valid;
        if (stage_valid) begin
          elapsed_ticks  <= elapsed_ticks_next;
          elapsed_scaled <= elapsed_scaled_next;
          fired_flag     <= fired_flag_next;
          last_zc        <= last_zc_next;
          last_irq       <= stage_word.zc_irq_level;
          pulse_left     <= pulse_left_next;
          crossing_count <= crossing_count_next;
          angle          <= angle_next;
          adjust_timer   <= adjust_timer_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_stage) begin
      stage_word <= in_word;
    end
    if (advance && stage_valid) begin
      out_word.gate           <= gate;
      out_word.firing_enabled <= enabled;
      out_word.angle_mdeg     <= angle_next;
    end
  end

  // The scaled timer must always track the tick count times a full turn.
  a_scaled_tracks: assert property (@(posedge clk) disable iff (rst)
    elapsed_scaled == PROD_W'(elapsed_ticks) * FULL_TURN_MDEG)
    else $error("scaled elapsed timer out of step with tick count");

  a_pulse_bound: assert property (@(posedge clk) disable iff (rst)
    pulse_left < PULSE_TICKS)
    else $error("gate pulse counter above its length");

  // A new firing always leaves the rest of a full pulse to run.
  a_fire_starts_pulse: assert property (@(posedge clk) disable iff (rst)
    $rose(fired_flag) |-> pulse_left == PULSE_TICKS - 4'd1)
    else $error("firing did not start a full gate pulse");

endmodule

`default_nettype wire
